// ----- src/bds_pkg.sv -----
`timescale 1ns / 1ps

package bds_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int LINE_AW    = $clog2(LINE_DEPTH);
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int NUM_CH     = 4;
	localparam int PIX_W      = 8;
	localparam int SUM_W      = PIX_W + 1;
	localparam int DIM_W      = 12;
	localparam int NCH_W      = 3;
	localparam int REG_IDX_W  = 2;
	localparam int LINE_W     = SUM_W * NUM_CH;

	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

	typedef logic [PIX_W-1:0] pix_byte_t;
	typedef pix_byte_t [NUM_CH-1:0] pixel_t;
	typedef logic [SUM_W-1:0] sum_t;
	typedef sum_t [NUM_CH-1:0] sums_t;

	typedef struct packed {
		logic               wr_en;
		logic               rd_en;
		logic               emit;
		logic               odd_row;
		logic               last;
		logic [LINE_AW-1:0] addr;
	} scan_info_t;

	// last valid position (size - 1) after clamping the size to 1..hi
	function automatic logic [DIM_W-1:0] clamp_last(input logic [DIM_W-1:0] v,
			input logic [DIM_W:0] hi);
		logic [DIM_W:0] r;
		if (v == '0) begin
			r = '0;
		end else if ({1'b0, v} > hi) begin
			r = hi - 1'b1;
		end else begin
			r = {1'b0, v} - 1'b1;
		end
		return r[DIM_W-1:0];
	endfunction

endpackage

// ----- src/bds_pix_in_if.sv -----
`timescale 1ns / 1ps

interface bds_pix_in_if;
	logic                   valid;
	logic                   ready;
	bds_pkg::pix_byte_t     in_ch0;
	bds_pkg::pix_byte_t     in_ch1;
	bds_pkg::pix_byte_t     in_ch2;
	bds_pkg::pix_byte_t     in_ch3;

	modport source (output valid, output in_ch0, output in_ch1, output in_ch2,
		output in_ch3, input ready);
	modport sink (input valid, input in_ch0, input in_ch1, input in_ch2,
		input in_ch3, output ready);
endinterface

// ----- src/bds_pix_out_if.sv -----
`timescale 1ns / 1ps

interface bds_pix_out_if;
	logic                   valid;
	logic                   ready;
	bds_pkg::pix_byte_t     out_ch0;
	bds_pkg::pix_byte_t     out_ch1;
	bds_pkg::pix_byte_t     out_ch2;
	bds_pkg::pix_byte_t     out_ch3;
	logic                   out_last;

	modport source (output valid, output out_ch0, output out_ch1, output out_ch2,
		output out_ch3, output out_last, input ready);
	modport sink (input valid, input out_ch0, input out_ch1, input out_ch2,
		input out_ch3, input out_last, output ready);
endinterface

// ----- src/bds_cfg_if.sv -----
`timescale 1ns / 1ps

interface bds_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [bds_pkg::REG_IDX_W-1:0]       index;
	logic [bds_pkg::DIM_W-1:0]           data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/bds_cfg.sv -----
`timescale 1ns / 1ps

module bds_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	bds_cfg_if.sink                     cfg,
	output logic [bds_pkg::COL_W-1:0]   col_last,
	output logic [bds_pkg::ROW_W-1:0]   row_last,
	output logic [bds_pkg::NCH_W-1:0]   nch
);

	logic [bds_pkg::DIM_W-1:0] col_last_q;
	logic [bds_pkg::DIM_W-1:0] row_last_q;
	logic [bds_pkg::NCH_W-1:0] nch_q;
	logic [bds_pkg::NCH_W-1:0] nch_wr;

	assign cfg.ready = 1'b1;

	always_comb begin
		nch_wr = cfg.data[bds_pkg::NCH_W-1:0];
		if (nch_wr == '0) begin
			nch_wr = bds_pkg::NCH_W'(1);
		end else if (nch_wr > bds_pkg::NCH_W'(bds_pkg::NUM_CH)) begin
			nch_wr = bds_pkg::NCH_W'(bds_pkg::NUM_CH);
		end
	end

	// store clamped last positions so the scan compares directly
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_last_q <= bds_pkg::DIM_W'(bds_pkg::MAX_WIDTH - 1);
			row_last_q <= bds_pkg::DIM_W'(bds_pkg::MAX_HEIGHT - 1);
			nch_q      <= bds_pkg::NCH_W'(bds_pkg::NUM_CH);
		end else if (cfg.valid) begin
			case (cfg.index)
				bds_pkg::REG_IMAGE_WIDTH: begin
					col_last_q <= bds_pkg::clamp_last(cfg.data,
						(bds_pkg::DIM_W + 1)'(bds_pkg::MAX_WIDTH));
				end
				bds_pkg::REG_IMAGE_HEIGHT: begin
					row_last_q <= bds_pkg::clamp_last(cfg.data,
						(bds_pkg::DIM_W + 1)'(bds_pkg::MAX_HEIGHT));
				end
				bds_pkg::REG_CHANNEL_COUNT: begin
					nch_q <= nch_wr;
				end
				default: begin
				end
			endcase
		end
	end

	assign col_last = col_last_q[bds_pkg::COL_W-1:0];
	assign row_last = row_last_q[bds_pkg::ROW_W-1:0];
	assign nch      = nch_q;

endmodule

// ----- src/bds_line_ram.sv -----
`timescale 1ns / 1ps

module bds_line_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 36
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- src/bds_scan.sv -----
`timescale 1ns / 1ps

module bds_scan (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  bds_pkg::pixel_t             pix,
	input  logic [bds_pkg::COL_W-1:0]   col_last,
	input  logic [bds_pkg::ROW_W-1:0]   row_last,
	output bds_pkg::scan_info_t         info,
	output bds_pkg::sums_t              row_sums
);

	logic [bds_pkg::COL_W-1:0] col_q;
	logic [bds_pkg::ROW_W-1:0] row_q;
	bds_pkg::pixel_t           hold_q;
	logic                      col_end;
	logic                      row_end;
	logic                      col_closes;
	logic                      row_closes;

	assign col_end    = (col_q >= col_last);
	assign row_end    = (row_q >= row_last);
	assign col_closes = col_q[0] | col_end;
	assign row_closes = row_q[0] | row_end;

	// horizontal pair sum; an even closing column has no partner
	always_comb begin
		for (int k = 0; k < bds_pkg::NUM_CH; k++) begin
			row_sums[k] = (col_q[0] ? {1'b0, hold_q[k]} : '0) + {1'b0, pix[k]};
		end
	end

	always_comb begin
		info.wr_en   = col_closes & ~row_closes;
		info.rd_en   = col_closes & row_closes & row_q[0];
		info.emit    = col_closes & row_closes;
		info.odd_row = row_q[0];
		info.last    = col_end & row_end;
		info.addr    = bds_pkg::LINE_AW'(col_q >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			hold_q <= '0;
		end else if (accept) begin
			if (!col_closes) begin
				hold_q <= pix;
			end
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

// ----- src/box_downsample_2x2.sv -----
`timescale 1ns / 1ps

// 2x2 box downsampler for a raster pixel stream.
// pixel: source pixels, row 0 first, column 0 first, four byte channels each.
// result: one pixel per 2x2 source block, each channel the block sum / 4,
//   truncated; missing pixels of an odd last row or column count as zero.
//   Channels at or above channel_count read zero. out_last flags the final
//   result of the image.
// cfg: register writes (0 width, 1 height, 2 channel count), always ready;
//   write only while the block is idle.
// Throughput: one pixel per cycle while no result stall holds pixel.ready
//   low. The line store is a single-port-per-direction RAM: even rows write
//   pair sums, odd rows read them back. The transaction of the pixel that
//   closes a block reads the line store and loads stage 1 on the same edge;
//   stage 1 then passes into the output register, from which it leaves.
// Reset: counters and pair register clear, registers return to 2048 x 2048
//   with four channels; the line store needs no clearing since each entry is
//   written in an even row before the odd row reads it.
// Stall: a held result parks in the output register; the stage behind it
//   still takes one more closing pixel, then pixel.ready drops.
module box_downsample_2x2 (
	input  logic          clk,
	input  logic          arst_n,
	bds_pix_in_if.sink    pixel,
	bds_pix_out_if.source result,
	bds_cfg_if.sink       cfg
);

	logic [bds_pkg::COL_W-1:0] col_last;
	logic [bds_pkg::ROW_W-1:0] row_last;
	logic [bds_pkg::NCH_W-1:0] nch;
	bds_pkg::pixel_t           pix;
	bds_pkg::scan_info_t       info;
	bds_pkg::sums_t            row_sums;
	logic [bds_pkg::LINE_W-1:0] line_rd;
	bds_pkg::sums_t            above_sums;

	logic                      in_acc;
	logic                      s1_adv;

	// stage 1: block closed, waiting on line store data
	logic                      valid_s1;
	bds_pkg::sums_t            sums_s1;
	logic                      odd_s1;
	logic                      last_s1;

	// output register
	logic                      out_valid_q;
	bds_pkg::pixel_t           out_pix_q;
	logic                      out_last_q;
	bds_pkg::pixel_t           avg;

	assign pix[0] = pixel.in_ch0;
	assign pix[1] = pixel.in_ch1;
	assign pix[2] = pixel.in_ch2;
	assign pix[3] = pixel.in_ch3;

	bds_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.col_last (col_last),
		.row_last (row_last),
		.nch      (nch)
	);

	bds_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (in_acc),
		.pix      (pix),
		.col_last (col_last),
		.row_last (row_last),
		.info     (info),
		.row_sums (row_sums)
	);

	// write and read never hit in the same transaction: a pixel either
	// stores an even-row pair sum or fetches one for an odd row
	bds_line_ram #(
		.DEPTH (bds_pkg::LINE_DEPTH),
		.WIDTH (bds_pkg::LINE_W)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (in_acc & info.wr_en),
		.wr_addr (info.addr),
		.wr_data (row_sums),
		.rd_en   (in_acc & info.rd_en),
		.rd_addr (info.addr),
		.rd_data (line_rd)
	);

	assign above_sums = line_rd;

	// advance stage 1 when the output register is free or being drained
	assign s1_adv      = valid_s1 & (~out_valid_q | result.ready);
	assign pixel.ready = ~valid_s1 | s1_adv;
	assign in_acc      = pixel.valid & pixel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc & info.emit) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc & info.emit) begin
			sums_s1 <= row_sums;
			odd_s1  <= info.odd_row;
			last_s1 <= info.last;
		end
	end

	// add the stored row above (zero on a lone last row), divide by four
	always_comb begin
		logic [bds_pkg::SUM_W:0] total;
		for (int k = 0; k < bds_pkg::NUM_CH; k++) begin
			total = (odd_s1 ? {1'b0, above_sums[k]} : '0) + {1'b0, sums_s1[k]};
			if (bds_pkg::NCH_W'(k) < nch) begin
				avg[k] = total[bds_pkg::SUM_W:2];
			end else begin
				avg[k] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_pix_q  <= avg;
			out_last_q <= last_s1;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.out_ch0  = out_pix_q[0];
	assign result.out_ch1  = out_pix_q[1];
	assign result.out_ch2  = out_pix_q[2];
	assign result.out_ch3  = out_pix_q[3];
	assign result.out_last = out_last_q;

`ifndef ASSERT_OFF
	a_ram_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(info.wr_en && info.rd_en))
		else $error("line store read and write requested together");

	a_emit_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && info.emit) |=> valid_s1)
		else $error("closing pixel did not reach stage 1");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		info.last |-> info.emit)
		else $error("final pixel of image does not close a block");

	a_s1_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> (out_valid_q && out_last_q == $past(last_s1)))
		else $error("stage 1 result lost on its way to the output");
`endif

endmodule

// ----- verif/bds_checker.sv -----
`timescale 1ns / 1ps

module bds_checker
	import bds_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	bds_pix_in_if  pixel,
	bds_pix_out_if result,
	bds_cfg_if     cfg,
	output int     fail_count,
	output int     pending,
	output int     result_total,
	output int     last_total
);

	typedef struct packed {
		pixel_t chans;
		logic   last;
	} down_pixel_t;

	down_pixel_t      expected_q[$];
	logic [DIM_W-1:0] width_reg;
	logic [DIM_W-1:0] height_reg;
	logic [NCH_W-1:0] nch_reg;
	pixel_t           held_pixel;
	sums_t            pair_sums [LINE_DEPTH];
	int               col_pos;
	int               row_pos;

	function automatic int effective(input int v, input int hi);
		if (v < 1) begin
			return 1;
		end
		if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	// advance the scan by one source pixel; returns 1 when a 2x2 block closes
	function automatic bit predict_pixel(input pixel_t pix, output down_pixel_t dp);
		int    w;
		int    h;
		int    nch;
		int    idx;
		int    above;
		int    total;
		bit    col_end;
		bit    row_last;
		bit    odd_col;
		bit    odd_row;
		bit    emit;
		sums_t row_pair;
		w = effective(int'(width_reg), MAX_WIDTH);
		h = effective(int'(height_reg), MAX_HEIGHT);
		nch = effective(int'(nch_reg), NUM_CH);
		col_end = (col_pos >= w - 1);
		row_last = (row_pos >= h - 1);
		odd_col = (col_pos % 2) == 1;
		odd_row = (row_pos % 2) == 1;
		idx = col_pos / 2;
		if (idx >= LINE_DEPTH) begin
			idx = LINE_DEPTH - 1;
		end
		emit = 1'b0;
		dp = '0;
		if (!(odd_col || col_end)) begin
			held_pixel = pix;
		end else begin
			for (int k = 0; k < NUM_CH; k++) begin
				row_pair[k] = sum_t'((odd_col ? int'(held_pixel[k]) : 0) + int'(pix[k]));
			end
			if (odd_row || row_last) begin
				for (int k = 0; k < NUM_CH; k++) begin
					above = odd_row ? int'(pair_sums[idx][k]) : 0;
					total = (above + int'(row_pair[k])) >> 2;
					dp.chans[k] = (k < nch) ? pix_byte_t'(total) : '0;
				end
				dp.last = col_end && row_last;
				emit = 1'b1;
			end else begin
				pair_sums[idx] = row_pair;
			end
		end
		if (col_end) begin
			col_pos = 0;
			row_pos = row_last ? 0 : row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
		return emit;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		down_pixel_t want;
		down_pixel_t got;
		if (!arst_n) begin
			width_reg = 12'd2048;
			height_reg = 12'd2048;
			nch_reg = 3'd4;
			held_pixel = '0;
			col_pos = 0;
			row_pos = 0;
			expected_q.delete();
			pending = 0;
		end else begin
			if (result.valid && result.ready) begin
				got.chans = {result.out_ch3, result.out_ch2, result.out_ch1, result.out_ch0};
				got.last = result.out_last;
				result_total++;
				if (got.last === 1'b1) begin
					last_total++;
				end
				if (expected_q.size() == 0) begin
					$display("%0t ns: result with none pending: expected nothing, actual %h last %b",
						$time, got.chans, got.last);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					if (want !== got) begin
						fail_count++;
						for (int k = 0; k < NUM_CH; k++) begin
							if (want.chans[k] !== got.chans[k]) begin
								$display("%0t ns: out_ch%0d expected %0d actual %0d",
									$time, k, want.chans[k], got.chans[k]);
							end
						end
						if (want.last !== got.last) begin
							$display("%0t ns: out_last expected %b actual %b",
								$time, want.last, got.last);
						end
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_IMAGE_WIDTH: width_reg = cfg.data;
					REG_IMAGE_HEIGHT: height_reg = cfg.data;
					REG_CHANNEL_COUNT: nch_reg = cfg.data[NCH_W-1:0];
					default: ;
				endcase
			end
			if (pixel.valid && pixel.ready) begin
				if (predict_pixel({pixel.in_ch3, pixel.in_ch2, pixel.in_ch1, pixel.in_ch0}, want)) begin
					expected_q.push_back(want);
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import bds_pkg::*;

	// index 3 maps to no register; writes to it must change nothing
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

	localparam int TIMEOUT_CYCLES   = 1_500_000;
	localparam int RANDOM_PIXELS    = 1050;
	localparam int DRAIN_CYCLES     = 6;
	localparam int LONG_HOLD_CYCLES = 150;

	logic clk;
	logic arst_n;

	bds_pix_in_if  pix_if ();
	bds_pix_out_if res_if ();
	bds_cfg_if     cfg_if ();

	int fail_count;
	int pending;
	int result_total;
	int last_total;

	int cycle_count   = 0;
	int sent_pixels   = 0;
	int random_pixels = 0;
	int images_sent   = 0;
	int settings_used = 0;
	int long_holds    = 0;

	// handshake between the stimulus and the receiver for the forced long stall
	bit long_hold_req    = 1'b0;
	bit long_hold_active = 1'b0;

	// register values as last written, to size the images
	logic [DIM_W-1:0] cur_width  = 12'd2048;
	logic [DIM_W-1:0] cur_height = 12'd2048;

	box_downsample_2x2 u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pix_if),
		.result (res_if),
		.cfg    (cfg_if)
	);

	bds_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel        (pix_if),
		.result       (res_if),
		.cfg          (cfg_if),
		.fail_count   (fail_count),
		.pending      (pending),
		.result_total (result_total),
		.last_total   (last_total)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= TIMEOUT_CYCLES) begin
			$display("FAIL box_downsample_2x2");
			$finish;
		end
	end

	// Bias channel bytes toward the extremes so the sums hit both ends.
	function automatic pixel_t random_pixel();
		pixel_t p;
		int     r;
		for (int k = 0; k < NUM_CH; k++) begin
			r = $urandom_range(0, 9);
			if (r == 0) begin
				p[k] = 8'h00;
			end else if (r == 1) begin
				p[k] = 8'hff;
			end else begin
				p[k] = pix_byte_t'($urandom_range(0, 255));
			end
		end
		return p;
	endfunction

	// Mostly back-to-back, some short gaps, a few long ones.
	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 8);
		end
		return $urandom_range(10, 40);
	endfunction

	// Size the block actually uses for a register value.
	function automatic int used_dim(input int v, input int hi);
		if (v == 0) begin
			return 1;
		end
		return (v > hi) ? hi : v;
	endfunction

	// Offer one pixel after an optional gap and hold it until the transaction.
	task automatic push_pixel(input pixel_t p, input int gap);
		if (gap > 0) begin
			@(negedge clk);
			pix_if.valid <= 1'b0;
			pix_if.in_ch0 <= pix_byte_t'($urandom_range(0, 255));
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		pix_if.valid <= 1'b1;
		pix_if.in_ch0 <= p[0];
		pix_if.in_ch1 <= p[1];
		pix_if.in_ch2 <= p[2];
		pix_if.in_ch3 <= p[3];
		do @(posedge clk); while (!pix_if.ready);
		sent_pixels++;
	endtask

	task automatic park_sender();
		@(negedge clk);
		pix_if.valid <= 1'b0;
	endtask

	// Stop offering, wait for every pending result, then let the pipe settle.
	task automatic wait_results();
		park_sender();
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int value);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= value[DIM_W-1:0];
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
		if (idx == REG_IMAGE_WIDTH) begin
			cur_width = value[DIM_W-1:0];
		end else if (idx == REG_IMAGE_HEIGHT) begin
			cur_height = value[DIM_W-1:0];
		end
	endtask

	// Send one whole image of random pixels; drain mid-image at pause_at.
	task automatic send_image(input bit steady, input int pause_at, input bit count_random);
		int total;
		total = used_dim(int'(cur_width), MAX_WIDTH) * used_dim(int'(cur_height), MAX_HEIGHT);
		for (int i = 0; i < total; i++) begin
			if (i == pause_at || (!steady && $urandom_range(0, 299) == 0)) begin
				wait_results();
			end
			push_pixel(random_pixel(), steady ? 0 : random_gap());
			if (count_random) begin
				random_pixels++;
			end
		end
		images_sent++;
	endtask

	// Receiver: random stalls of mixed length, no-stall stretches, and the
	// forced long stall when the stimulus asks for one.
	initial begin : receiver
		int r;
		int len;
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				long_hold_active = 1'b1;
				@(negedge clk);
				res_if.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
				long_hold_active = 1'b0;
				long_holds++;
			end else begin
				r = $urandom_range(0, 99);
				@(negedge clk);
				if (r < 55) begin
					res_if.ready <= 1'b1;
					len = $urandom_range(1, 12);
				end else if (r < 65) begin
					res_if.ready <= 1'b1;
					len = $urandom_range(30, 60);
				end else if (r < 92) begin
					res_if.ready <= 1'b0;
					len = $urandom_range(1, 3);
				end else begin
					res_if.ready <= 1'b0;
					len = $urandom_range(8, 30);
				end
				repeat (len - 1) @(negedge clk);
			end
		end
	end

	initial begin : stimulus
		int  n_images;
		bit  steady;
		bit  first_random;
		int  r;
		pix_if.valid = 1'b0;
		pix_if.in_ch0 = '0;
		pix_if.in_ch1 = '0;
		pix_if.in_ch2 = '0;
		pix_if.in_ch3 = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_IMAGE_WIDTH;
		cfg_if.data = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (DRAIN_CYCLES) @(negedge clk);

		// Directed: 3x3 image with odd last row and column; channel count
		// left at its reset value of four.
		write_reg(REG_IMAGE_WIDTH, 3);
		write_reg(REG_IMAGE_HEIGHT, 3);
		settings_used++;
		push_pixel(32'hffffffff, 0);
		push_pixel(32'hffffffff, 0);
		push_pixel(32'h01020304, 0);
		push_pixel(32'hffffffff, 0);
		push_pixel(32'hffffffff, 1);
		push_pixel(32'haa55aa55, 0);
		push_pixel(32'h00000000, 0);
		push_pixel(32'h80808080, 2);
		push_pixel(32'hff00ff00, 0);
		images_sent++;
		wait_results();

		// Directed: 2x2 with one channel; upper channels must read zero.
		write_reg(REG_IMAGE_WIDTH, 2);
		write_reg(REG_IMAGE_HEIGHT, 2);
		write_reg(REG_CHANNEL_COUNT, 1);
		settings_used++;
		push_pixel(32'h03030303, 0);
		push_pixel(32'h01010101, 0);
		push_pixel(32'hffffffff, 0);
		push_pixel(32'h7f7f7f7f, 0);
		images_sent++;
		wait_results();

		// Directed: single-pixel image, channel count zero (used as one).
		write_reg(REG_IMAGE_WIDTH, 1);
		write_reg(REG_IMAGE_HEIGHT, 1);
		write_reg(REG_CHANNEL_COUNT, 0);
		settings_used++;
		push_pixel(32'hffffffff, 0);
		images_sent++;
		wait_results();

		// Directed: channel count above four (used as four), then a write to
		// the unmapped index, which must leave the setting alone.
		write_reg(REG_CHANNEL_COUNT, 7);
		write_reg(REG_SPARE, 12'hfff);
		settings_used++;
		push_pixel(32'hfcfdfeff, 0);
		images_sent++;
		wait_results();

		// Directed: one row of two with three channels, one column of two
		// with two channels.
		write_reg(REG_IMAGE_WIDTH, 2);
		write_reg(REG_CHANNEL_COUNT, 3);
		settings_used++;
		push_pixel(32'h80ff0001, 0);
		push_pixel(32'h7f01ff03, 0);
		images_sent++;
		wait_results();
		write_reg(REG_IMAGE_WIDTH, 1);
		write_reg(REG_IMAGE_HEIGHT, 2);
		write_reg(REG_CHANNEL_COUNT, 2);
		settings_used++;
		push_pixel(32'h5555aaff, 0);
		push_pixel(32'haa5555ff, 0);
		images_sent++;
		wait_results();

		// Extremes: odd width with height zero (used as one).
		write_reg(REG_IMAGE_WIDTH, 5);
		write_reg(REG_IMAGE_HEIGHT, 0);
		write_reg(REG_CHANNEL_COUNT, 1);
		settings_used++;
		send_image(1'b0, -1, 1'b0);
		wait_results();

		// Extremes: width zero (used as one), odd height, one column.
		write_reg(REG_IMAGE_WIDTH, 0);
		write_reg(REG_IMAGE_HEIGHT, 3);
		write_reg(REG_CHANNEL_COUNT, 4);
		settings_used++;
		send_image(1'b0, -1, 1'b0);
		wait_results();

		// Random settings, one to three images each. The first phase forces a
		// long output stall against a steady input and a mid-image drain.
		first_random = 1'b1;
		while (random_pixels < RANDOM_PIXELS) begin
			wait_results();
			if (first_random) begin
				write_reg(REG_IMAGE_WIDTH, 32);
				write_reg(REG_IMAGE_HEIGHT, 8);
				write_reg(REG_CHANNEL_COUNT, $urandom_range(0, 7));
			end else begin
				if ($urandom_range(0, 3) != 0) begin
					r = $urandom_range(0, 99);
					write_reg(REG_IMAGE_WIDTH, (r < 70) ? $urandom_range(1, 8) :
						(r < 92) ? $urandom_range(9, 40) : 0);
				end
				if ($urandom_range(0, 3) != 0) begin
					r = $urandom_range(0, 99);
					write_reg(REG_IMAGE_HEIGHT, (r < 80) ? $urandom_range(1, 6) :
						(r < 93) ? $urandom_range(7, 12) : 0);
				end
				if ($urandom_range(0, 3) != 0) begin
					write_reg(REG_CHANNEL_COUNT, $urandom_range(0, 7));
				end
				if ($urandom_range(0, 9) == 0) begin
					write_reg(REG_SPARE, $urandom_range(0, 4095));
				end
			end
			settings_used++;
			if (first_random) begin
				long_hold_req = 1'b1;
				while (!long_hold_active) @(negedge clk);
				send_image(1'b1, 200, 1'b1);
				first_random = 1'b0;
			end else begin
				n_images = $urandom_range(1, 3);
				steady = ($urandom_range(0, 3) == 0);
				// back-to-back images: the scan wraps without a register write
				for (int i = 0; i < n_images; i++) begin
					if (random_pixels >= RANDOM_PIXELS) begin
						break;
					end
					send_image(steady, -1, 1'b1);
				end
			end
		end

		wait_results();
		$display("Run covered %0d source pixels in %0d images over %0d register settings.",
			sent_pixels, images_sent, settings_used);
		$display("Checked %0d output pixels, %0d end-of-image flags, %0d forced long stalls.",
			result_total, last_total, long_holds);
		if (fail_count == 0) begin
			$display("PASS box_downsample_2x2");
		end else begin
			$display("FAIL box_downsample_2x2");
		end
		$finish;
	end

endmodule
